FILE: rtl/srfr_pkg.sv
package srfr_pkg;

  localparam int          MAX_LENGTH   = 7;
  localparam logic [7:0]  BROADCAST_ID = 8'd254;
  localparam int          NUM_PARAMS   = 4;
  localparam int          FIXED_BYTES  = 3;
  localparam int          LEFT_W       = (MAX_LENGTH > FIXED_BYTES + 1)
                                         ? $clog2(MAX_LENGTH - FIXED_BYTES + 1) : 1;

  localparam logic [2:0]  ST_OK          = 3'd0;
  localparam logic [2:0]  ST_BAD_LENGTH  = 3'd1;
  localparam logic [2:0]  ST_BAD_CHECKSUM = 3'd2;
  localparam logic [2:0]  ST_BAD_COMMAND = 3'd3;
  localparam logic [2:0]  ST_BAD_SERVO   = 3'd4;

  localparam logic [1:0]  CFG_HEADER_BYTE      = 2'd0;
  localparam logic [1:0]  CFG_EXPECTED_SERVO   = 2'd1;
  localparam logic [1:0]  CFG_EXPECTED_COMMAND = 2'd2;

  localparam logic [7:0]  HEADER_RESET   = 8'd85;
  localparam logic [7:0]  SERVO_RESET    = 8'd254;
  localparam logic [7:0]  COMMAND_RESET  = 8'd0;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } srfr_byte_t;

  typedef struct packed {
    logic       write;
    logic [1:0] index;
    logic [7:0] data;
  } srfr_cfg_wr_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] resp_servo;
    logic [7:0] resp_command;
    logic [2:0] param_count;
    logic [7:0] param_a;
    logic [7:0] param_b;
    logic [7:0] param_c;
    logic [7:0] param_d;
  } srfr_result_t;

endpackage

FILE: rtl/srfr_byte_if.sv
interface srfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/srfr_resp_if.sv
interface srfr_resp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] resp_servo;
  logic [7:0] resp_command;
  logic [2:0] param_count;
  logic [7:0] param_a;
  logic [7:0] param_b;
  logic [7:0] param_c;
  logic [7:0] param_d;

  modport source (
    output valid, output status, output resp_servo, output resp_command,
    output param_count, output param_a, output param_b, output param_c,
    output param_d, input ready
  );
  modport sink (
    input valid, input status, input resp_servo, input resp_command,
    input param_count, input param_a, input param_b, input param_c,
    input param_d, output ready
  );
endinterface

FILE: rtl/srfr_in_reg.sv
module srfr_in_reg
  import srfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  srfr_byte_if.sink  rx,
  input  logic       take,
  output srfr_byte_t held
);

  logic       valid;
  logic [7:0] data;

  assign rx.ready   = !valid || take;
  assign held.valid = valid;
  assign held.data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rx.ready) begin
      valid <= rx.valid;
    end
    if (rx.ready && rx.valid) begin
      data <= rx.rx_byte;
    end
  end

endmodule

FILE: rtl/srfr_parser.sv
module srfr_parser
  import srfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  srfr_cfg_wr_t cfg,
  input  srfr_byte_t   held,
  input  logic         out_free,
  output logic         take,
  output logic         push,
  output srfr_result_t result
);

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_ID,
    PH_LEN,
    PH_CMD,
    PH_PARAM,
    PH_CHECK
  } phase_t;

  phase_t              phase, phase_next;
  logic [7:0]          header_byte;
  logic [7:0]          expected_servo;
  logic [7:0]          expected_command;
  logic [7:0]          frame_servo;
  logic [7:0]          frame_length;
  logic [7:0]          frame_command;
  logic [7:0]          running_sum;
  logic [2:0]          param_index;
  logic [LEFT_W-1:0]   params_left;
  logic [7:0]          param_store [NUM_PARAMS];
  logic                emits;
  logic [7:0]          b;
  logic                too_long;
  logic [NUM_PARAMS-1:0] keep;

  assign b        = held.data;
  assign too_long = frame_length > 8'(MAX_LENGTH);

  always_comb begin
    for (int i = 0; i < NUM_PARAMS; i++) begin
      keep[i] = 3'(i) < param_index;
    end
  end

  always_comb begin
    emits      = 1'b0;
    phase_next = phase;
    result     = '0;
    result.resp_servo = frame_servo;
    case (phase)
      PH_HUNT1: begin
        if (b == header_byte) phase_next = PH_HUNT2;
      end
      PH_HUNT2: begin
        phase_next = (b == header_byte) ? PH_ID : PH_HUNT1;
      end
      PH_ID:  phase_next = PH_LEN;
      PH_LEN: phase_next = PH_CMD;
      PH_CMD: begin
        result.resp_command = b;
        result.status       = ST_BAD_LENGTH;
        if (too_long) begin
          emits      = 1'b1;
          phase_next = PH_HUNT1;
        end else if (frame_length > 8'(FIXED_BYTES)) begin
          phase_next = PH_PARAM;
        end else begin
          phase_next = PH_CHECK;
        end
      end
      PH_PARAM: begin
        if (params_left == LEFT_W'(1)) phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        emits               = 1'b1;
        phase_next          = PH_HUNT1;
        result.resp_command = frame_command;
        result.param_count  = param_index;
        result.param_a      = keep[0] ? param_store[0] : 8'd0;
        result.param_b      = keep[1] ? param_store[1] : 8'd0;
        result.param_c      = keep[2] ? param_store[2] : 8'd0;
        result.param_d      = keep[3] ? param_store[3] : 8'd0;
        if (~running_sum != b) begin
          result.status = ST_BAD_CHECKSUM;
        end else if (frame_command != expected_command) begin
          result.status = ST_BAD_COMMAND;
        end else if (expected_servo != BROADCAST_ID && frame_servo != expected_servo) begin
          result.status = ST_BAD_SERVO;
        end else begin
          result.status = ST_OK;
        end
      end
      default: phase_next = PH_HUNT1;
    endcase
  end

  assign take = held.valid && (!emits || out_free);
  assign push = take && emits;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte      <= HEADER_RESET;
      expected_servo   <= SERVO_RESET;
      expected_command <= COMMAND_RESET;
    end else if (cfg.write) begin
      case (cfg.index)
        CFG_HEADER_BYTE:      header_byte      <= cfg.data;
        CFG_EXPECTED_SERVO:   expected_servo   <= cfg.data;
        CFG_EXPECTED_COMMAND: expected_command <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT1;
      param_index <= '0;
      params_left <= '0;
    end else if (take) begin
      phase <= phase_next;
      case (phase)
        PH_ID: begin
          frame_servo <= b;
          running_sum <= b;
          param_index <= '0;
        end
        PH_LEN: begin
          frame_length <= b;
          running_sum  <= running_sum + b;
        end
        PH_CMD: begin
          frame_command <= b;
          running_sum   <= running_sum + b;
          params_left   <= (frame_length > 8'(FIXED_BYTES))
                           ? LEFT_W'(frame_length - 8'(FIXED_BYTES)) : '0;
        end
        PH_PARAM: begin
          running_sum <= running_sum + b;
          if (param_index < 3'(NUM_PARAMS)) begin
            param_store[param_index[1:0]] <= b;
            param_index <= param_index + 3'd1;
          end
          params_left <= params_left - LEFT_W'(1);
        end
        default: ;
      endcase
    end
  end

  a_push_takes: assert property (@(posedge clk) disable iff (rst)
    push |-> take && held.valid && out_free)
    else $error("result pushed without consuming a byte into a free slot");

  a_ok_matches: assert property (@(posedge clk) disable iff (rst)
    push && result.status == ST_OK |-> result.resp_command == expected_command)
    else $error("ok status with unexpected command");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    push |-> result.param_count <= 3'(NUM_PARAMS))
    else $error("parameter count out of range");

  a_hunt_after_result: assert property (@(posedge clk) disable iff (rst)
    push |=> phase == PH_HUNT1)
    else $error("parser did not return to hunting after a result");

endmodule

FILE: rtl/srfr_out_reg.sv
module srfr_out_reg
  import srfr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  srfr_result_t  result,
  output logic          out_free,
  srfr_resp_if.source   resp
);

  logic         valid;
  srfr_result_t data;

  assign out_free          = !valid || resp.ready;
  assign resp.valid        = valid;
  assign resp.status       = data.status;
  assign resp.resp_servo   = data.resp_servo;
  assign resp.resp_command = data.resp_command;
  assign resp.param_count  = data.param_count;
  assign resp.param_a      = data.param_a;
  assign resp.param_b      = data.param_b;
  assign resp.param_c      = data.param_c;
  assign resp.param_d      = data.param_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= push;
    end
    if (out_free && push) begin
      data <= result;
    end
  end

endmodule

FILE: rtl/servo_response_frame_receiver.sv
// Servo bus response frame receiver.
// rx carries one received serial byte per transaction; resp carries one
// parsed frame per transaction (status, servo id, command, up to four
// parameter bytes and their count). Frames are header, header, id, length,
// command, parameters, checksum; a result is produced at the checksum byte,
// or at the command byte when the length is above the limit.
// Configuration: cfg_write with cfg_index 0 header byte, 1 expected servo,
// 2 expected command; write only while no frame is in flight.
// Throughput: one byte per cycle, set by the single parse step between the
// input register and the result register, except while a byte that would
// give a result waits for the result register. The result of a checksum
// byte goes from the parse step into the result register, which drives resp.
// When resp stalls, the parser still consumes bytes that give no result;
// a byte that would give a result waits in the input register and rx.ready
// drops until the result register is free.
// Reset (rst, synchronous) restores the configuration defaults, empties
// both registers and returns the parser to hunting for the header.
module servo_response_frame_receiver
  import srfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  srfr_byte_if.sink   rx,
  srfr_resp_if.source resp,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  srfr_byte_t   held;
  srfr_cfg_wr_t cfg;
  srfr_result_t result;
  logic         take;
  logic         push;
  logic         out_free;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  srfr_in_reg u_in_reg (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .take (take),
    .held (held)
  );

  srfr_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .held     (held),
    .out_free (out_free),
    .take     (take),
    .push     (push),
    .result   (result)
  );

  srfr_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .result   (result),
    .out_free (out_free),
    .resp     (resp)
  );

endmodule
